// ===== src/bttrk_pkg.sv =====
// shared types and constants of the branch trace call stack tracker
package bttrk_pkg;

    localparam int APB_AW = 3;

    localparam logic REG_FOLLOW = 1'b0;
    localparam logic REG_WINDOW = 1'b1;

    localparam logic [3:0] WINDOW_RST = 4'd5;

    localparam logic [2:0] K_INR  = 3'd0;
    localparam logic [2:0] K_CALL = 3'd1;
    localparam logic [2:0] K_RET  = 3'd2;
    localparam logic [2:0] K_OOR  = 3'd3;
    localparam logic [2:0] K_INL  = 3'd4;
    localparam logic [2:0] K_OVF  = 3'd5;

    typedef struct packed {
        logic       ld_in;
        logic       push;
        logic       srch_init;
        logic       srch_dec;
        logic       pop_depth;
        logic       cur_zero;
        logic       cur_frame;
        logic       kind_we;
        logic [2:0] kind;
        logic       out_ld;
    } t_cmd;

    typedef struct packed {
        logic is_func;
        logic is_inl;
        logic follow;
        logic full;
        logic depth_zero;
        logic idx_zero;
        logic match;
        logic out_of_range;
        logic out_free;
    } t_sts;

endpackage

// ===== src/bttrk_ctrl.sv =====
// controller state machine of the call stack tracker
module bttrk_ctrl
    import bttrk_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_LDF  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.ld_in = 1'b1;
                    n_state     = S_DEC;
                end
            end
            S_DEC: begin
                if (i_sts.is_func) begin
                    o_cmd.kind_we = 1'b1;
                    n_state       = S_FIN;
                    if (i_sts.is_inl && !i_sts.follow) begin
                        o_cmd.kind = K_INL;
                    end else if (i_sts.full) begin
                        o_cmd.kind = K_OVF;
                    end else begin
                        o_cmd.kind = K_CALL;
                        o_cmd.push = 1'b1;
                    end
                end else if (i_sts.depth_zero) begin
                    o_cmd.kind_we = 1'b1;
                    o_cmd.kind    = K_INR;
                    n_state       = S_FIN;
                end else begin
                    o_cmd.srch_init = 1'b1;
                    n_state         = S_RD;
                end
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (i_sts.match) begin
                    o_cmd.pop_depth = 1'b1;
                    if (i_sts.idx_zero) begin
                        o_cmd.cur_zero = 1'b1;
                        o_cmd.kind_we  = 1'b1;
                        o_cmd.kind     = K_RET;
                        n_state        = S_FIN;
                    end else begin
                        n_state = S_LDF;
                    end
                end else if (i_sts.idx_zero) begin
                    o_cmd.kind_we = 1'b1;
                    o_cmd.kind    = i_sts.out_of_range ? K_OOR : K_INR;
                    n_state       = S_FIN;
                end else begin
                    o_cmd.srch_dec = 1'b1;
                    n_state        = S_RD;
                end
            end
            S_LDF: begin
                o_cmd.cur_frame = 1'b1;
                o_cmd.kind_we   = 1'b1;
                o_cmd.kind      = K_RET;
                n_state         = S_FIN;
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_ld = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/bttrk_dp.sv =====
// datapath of the call stack tracker: stack memories, depth, range and result register
module bttrk_dp
    import bttrk_pkg::*;
#(
    parameter int STACK_DEPTH = 1024,
    parameter int ADDR_BITS   = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic        i_follow,
    input  logic [3:0]  i_window,
    input  logic [31:0] i_src,
    input  logic [31:0] i_tgt,
    input  logic        i_func,
    input  logic        i_inl,
    input  logic [31:0] i_flo,
    input  logic [31:0] i_fhi,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_kind,
    output logic [9:0]  o_depth_before,
    output logic [9:0]  o_depth_after,
    output logic [31:0] o_range_low,
    output logic [31:0] o_range_high
);

    localparam int DW = $clog2(STACK_DEPTH);
    localparam int AW = ADDR_BITS;

    logic [AW-1:0]   r_sites [STACK_DEPTH];
    logic [2*AW-1:0] r_frm   [STACK_DEPTH];

    logic [AW-1:0]   r_src, r_tgt, r_flo, r_fhi;
    logic            r_func, r_inl;
    logic [DW-1:0]   r_depth, r_before, r_idx;
    logic [AW-1:0]   r_cur_lo, r_cur_hi, r_seen_lo, r_seen_hi;
    logic [2:0]      r_kind;
    logic [AW-1:0]   r_site_q;
    logic [2*AW-1:0] r_frm_q;
    logic            r_out_valid;
    logic [2:0]      r_o_kind;
    logic [DW-1:0]   r_o_before, r_o_after;
    logic [AW-1:0]   r_o_lo, r_o_hi;

    logic [AW+31:0]  w_src_x, w_tgt_x, w_flo_x, w_fhi_x;
    logic [AW-1:0]   w_new_lo, w_new_hi, w_diff;
    logic [DW:0]     w_depth_x;
    logic [DW+9:0]   w_bef_x, w_aft_x;
    logic [AW+31:0]  w_lo_x, w_hi_x;

    assign w_src_x = {{AW{1'b0}}, i_src};
    assign w_tgt_x = {{AW{1'b0}}, i_tgt};
    assign w_flo_x = {{AW{1'b0}}, i_flo};
    assign w_fhi_x = {{AW{1'b0}}, i_fhi};

    // unknown range inherits the current one
    assign w_new_lo = (r_flo != '0 || r_fhi != '0) ? r_flo : r_cur_lo;
    assign w_new_hi = (r_flo != '0 || r_fhi != '0) ? r_fhi : r_cur_hi;

    assign w_diff    = r_tgt - r_site_q;
    assign w_depth_x = {1'b0, r_depth};

    assign o_sts.is_func      = r_func;
    assign o_sts.is_inl       = r_inl;
    assign o_sts.follow       = i_follow;
    assign o_sts.full         = (w_depth_x >= (DW+1)'(STACK_DEPTH - 1));
    assign o_sts.depth_zero   = (r_depth == '0);
    assign o_sts.idx_zero     = (r_idx == '0);
    assign o_sts.match        = (r_tgt > r_site_q) && (w_diff <= AW'(i_window));
    assign o_sts.out_of_range = (r_tgt < r_cur_lo) || (r_tgt >= r_cur_hi);
    assign o_sts.out_free     = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_sites[r_depth]            <= r_src;
            r_frm[DW'(r_depth + 1'b1)] <= {w_new_hi, w_new_lo};
        end
        r_site_q <= r_sites[r_idx];
        r_frm_q  <= r_frm[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth     <= '0;
            r_cur_lo    <= '0;
            r_cur_hi    <= '1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.push) begin
                r_depth  <= DW'(r_depth + 1'b1);
                r_cur_lo <= w_new_lo;
                r_cur_hi <= w_new_hi;
            end else if (i_cmd.pop_depth) begin
                r_depth <= r_idx;
            end
            if (i_cmd.cur_zero) begin
                r_cur_lo <= '0;
                r_cur_hi <= '0;
            end else if (i_cmd.cur_frame) begin
                r_cur_lo <= r_frm_q[AW-1:0];
                r_cur_hi <= r_frm_q[2*AW-1:AW];
            end
            if (i_cmd.out_ld) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_in) begin
            r_src     <= w_src_x[AW-1:0];
            r_tgt     <= w_tgt_x[AW-1:0];
            r_flo     <= w_flo_x[AW-1:0];
            r_fhi     <= w_fhi_x[AW-1:0];
            r_func    <= i_func;
            r_inl     <= i_inl;
            r_before  <= r_depth;
            r_seen_lo <= r_cur_lo;
            r_seen_hi <= r_cur_hi;
        end
        if (i_cmd.srch_init) begin
            r_idx <= DW'(r_depth - 1'b1);
        end else if (i_cmd.srch_dec) begin
            r_idx <= DW'(r_idx - 1'b1);
        end
        if (i_cmd.kind_we) begin
            r_kind <= i_cmd.kind;
        end
        if (i_cmd.out_ld) begin
            r_o_kind   <= r_kind;
            r_o_before <= r_before;
            r_o_after  <= r_depth;
            r_o_lo     <= r_seen_lo;
            r_o_hi     <= r_seen_hi;
        end
    end

    assign w_bef_x = {10'b0, r_o_before};
    assign w_aft_x = {10'b0, r_o_after};
    assign w_lo_x  = {32'b0, r_o_lo};
    assign w_hi_x  = {32'b0, r_o_hi};

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_o_kind;
    assign o_depth_before = w_bef_x[9:0];
    assign o_depth_after  = w_aft_x[9:0];
    assign o_range_low    = w_lo_x[31:0];
    assign o_range_high   = w_hi_x[31:0];

endmodule

// ===== src/branch_trace_call_stack_tracker_core.sv =====
// top level of the branch trace call stack tracker: config registers and stream ports
//
// channel      | dir | beat contents
// s_axis       | in  | branch record with symbol verdict on the target
// m_axis       | out | event kind, depths and range seen
// apb          | in  | follow_inlined at 0x0, return_window at 0x4
//
// calls, ignored inlined entries, overflows and top-level branches pass IDLE, DEC and FIN
// other branches search the stack top down, one RD and CMP pass per frame read, plus LDF on a
// return to a level above 0; frames are read one at a time through the single stack read port
// one branch in flight; the next is taken while a result waits on m_axis
// reset: depth 0, range [0, all ones), follow_inlined 0, return_window 5
module branch_trace_call_stack_tracker_core
    import bttrk_pkg::*;
#(
    parameter int STACK_DEPTH = 1024,
    parameter int ADDR_BITS   = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // branch_source, branch_target, function_low, function_high
    input  logic [127:0]      s_axis_tdata,
    // target_is_function, target_is_inlined
    input  logic [1:0]        s_axis_tuser,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // depth_before, depth_after, range_low_seen, range_high_seen, zero pad
    output logic [87:0]       m_axis_tdata,
    // event_kind
    output logic [2:0]        m_axis_tuser,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic       r_follow;
    logic [3:0] r_window;
    t_cmd       w_cmd;
    t_sts       w_sts;
    logic [2:0] w_kind;
    logic [9:0] w_bef, w_aft;
    logic [31:0] w_lo, w_hi;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_follow <= 1'b0;
            r_window <= WINDOW_RST;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_FOLLOW: r_follow <= pwdata[0];
                REG_WINDOW: r_window <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_FOLLOW: prdata = {31'b0, r_follow};
            REG_WINDOW: prdata = {28'b0, r_window};
            default:    prdata = '0;
        endcase
    end

    bttrk_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    bttrk_dp #(
        .STACK_DEPTH (STACK_DEPTH),
        .ADDR_BITS   (ADDR_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_follow       (r_follow),
        .i_window       (r_window),
        .i_src          (s_axis_tdata[31:0]),
        .i_tgt          (s_axis_tdata[63:32]),
        .i_func         (s_axis_tuser[0]),
        .i_inl          (s_axis_tuser[1]),
        .i_flo          (s_axis_tdata[95:64]),
        .i_fhi          (s_axis_tdata[127:96]),
        .o_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .o_kind         (w_kind),
        .o_depth_before (w_bef),
        .o_depth_after  (w_aft),
        .o_range_low    (w_lo),
        .o_range_high   (w_hi)
    );

    assign m_axis_tuser = w_kind;
    assign m_axis_tdata = {4'b0, w_hi, w_lo, w_aft, w_bef};

endmodule

// ===== src/bttrk_chk.sv =====
// port-level checker of the call stack tracker and its bind
module bttrk_chk
    import bttrk_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [87:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);

    logic [9:0] w_bef, w_aft;
    logic       w_obeat;

    assign w_bef   = m_axis_tdata[9:0];
    assign w_aft   = m_axis_tdata[19:10];
    assign w_obeat = m_axis_tvalid && m_axis_tready;

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_call_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_obeat && m_axis_tuser == K_CALL |-> w_aft == 10'(w_bef + 1'b1))
        else $error("call did not deepen by one");

    a_flat_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_obeat && (m_axis_tuser == K_INR || m_axis_tuser == K_OOR
        || m_axis_tuser == K_INL || m_axis_tuser == K_OVF) |-> w_aft == w_bef)
        else $error("depth changed on a non call non return beat");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken twice in a row");

endmodule

bind branch_trace_call_stack_tracker_core bttrk_chk u_bttrk_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
